>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the plane builder blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define PFP_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PFP_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hw/rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// Plane builder package
// Types, constants and helpers shared by the plane builder modules.
// ----------------------------------------------------------------------------
package pfp_pkg;

   // Number of cells in the square root and divider chains.
   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 31;

   // First trial bit of the square root (bit 62 of a 64-bit radicand).
   localparam logic [63:0] SQRT_FIRST_BIT = 64'h4000_0000_0000_0000;

   // One in Q1.30.
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;

   // Rounding offset and limits of the distance.
   localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_2000_0000;
   localparam logic signed [63:0] DIST_MAX   = 64'sh0000_0003_FFFF_FFFF;
   localparam logic signed [63:0] DIST_MIN   = -64'sh0000_0004_0000_0000;

   // Point count codes.
   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   // What the word in flight turns into at the output.
   typedef enum logic [1:0] {
      KIND_PLANE,
      KIND_FLAT,
      KIND_DEGEN
   } kind_type;

   // Side information that travels with every word.
   typedef struct packed {
      logic            valid;
      kind_type        kind;
      logic [2:0]      neg;
      logic [2:0][31:0] pt;
   } tag_type;

   // Square root cell payload.
   typedef struct packed {
      logic [63:0]      rem;
      logic [63:0]      root;
      logic [63:0]      bitv;
      logic [2:0][30:0] mag;
   } sqrt_type;

   // Divider cell payload: three lanes share one divisor.
   typedef struct packed {
      logic [31:0]      len;
      logic [2:0][31:0] rem;
      logic [2:0][30:0] work;
   } div_type;

   // Position of the highest set bit plus one; zero for a zero word.
   function automatic logic [6:0] bit_length(input logic [66:0] v);
      logic [6:0] bl;
      bl = 7'd0;
      for (int i = 0; i < 67; i++) begin
         if (v[i]) begin
            bl = 7'(i + 1);
         end
      end
      return bl;
   endfunction

endpackage

>>> hw/rtl/plane_from_points.sv
// ----------------------------------------------------------------------------
// Plane from points
// Builds a unit normal and a distance from one, two or three points.
// ----------------------------------------------------------------------------
// The block takes one point set per clock cycle while the result side does
// not stall and returns one plane word per point set, in order. The pipeline
// is made of the cell chains: 32 square root cells and 31 divider cells, one
// step each, plus the cross product, scaling and distance stages around them.
// A stall on the result side holds the whole pipeline, so the input is ready
// exactly when the output register is empty or being taken.
`include "assert_macros.svh"

module plane_from_points (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z,
   // third_x, third_y, third_z
   input  logic [287:0] req_tdata,
   // point_count
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x, normal_y, normal_z, distance, zero fill
   output logic [135:0] rsp_tdata,
   // degenerate
   output logic [0:0]   rsp_tuser
);

   localparam int unsigned SQ_N  = pfp_pkg::SQRT_STEPS;
   localparam int unsigned DIV_N = pfp_pkg::DIV_STEPS;

   logic              advance;
   pfp_pkg::tag_type  fr_tag;
   logic [2:0][66:0]  fr_cross;
   pfp_pkg::tag_type  sq_tag [SQ_N + 1];
   pfp_pkg::sqrt_type sq_pl  [SQ_N + 1];
   pfp_pkg::tag_type  dv_tag [DIV_N + 1];
   pfp_pkg::div_type  dv_pl  [DIV_N + 1];

   logic [61:0]       num [3];
   pfp_pkg::div_type  div0_in;
   pfp_pkg::div_type  div0_ff;
   pfp_pkg::tag_type  div0_tag_ff;

   logic signed [31:0] nrm_in  [3];
   logic signed [31:0] nrm_ff  [3];
   logic signed [63:0] dprod_in [3];
   logic signed [63:0] dprod_ff [3];
   logic signed [31:0] nrm2_ff [3];
   pfp_pkg::tag_type   f1_tag_ff;
   pfp_pkg::tag_type   f2_tag_ff;

   logic signed [63:0] acc;
   logic signed [63:0] dsh;
   logic signed [63:0] dsat;
   logic [31:0]        onx_in, ony_in, onz_in;
   logic [34:0]        odist_in;
   logic               odeg_in;
   logic [31:0]        onx_ff, ony_ff, onz_ff;
   logic [34:0]        odist_ff;
   logic               odeg_ff;
   logic               ovalid_ff;

   // The pipeline moves whenever the output register can take a word.
   assign advance    = !ovalid_ff || rsp_tready;
   assign req_tready = advance;

   pfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .up_valid    (req_tvalid),
      .point_count (req_tuser),
      .first_pt    (req_tdata[95:0]),
      .second_pt   (req_tdata[191:96]),
      .third_pt    (req_tdata[287:192]),
      .dn_tag      (fr_tag),
      .dn_cross    (fr_cross)
   );

   pfp_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .up_tag   (fr_tag),
      .up_cross (fr_cross),
      .dn_tag   (sq_tag[0]),
      .dn_sq    (sq_pl[0])
   );

   // Square root chain.
   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      pfp_sqrt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (advance),
         .up_tag (sq_tag[k]),
         .up_sq  (sq_pl[k]),
         .dn_tag (sq_tag[k + 1]),
         .dn_sq  (sq_pl[k + 1])
      );
   end

   // Rounded dividends: magnitude scaled by 2^30 plus half the length.
   always_comb begin
      div0_in.len = sq_pl[SQ_N].root[31:0];
      for (int i = 0; i < 3; i++) begin
         num[i] = {sq_pl[SQ_N].mag[i], 31'b0} >> 1;
         num[i] = num[i] + 62'(sq_pl[SQ_N].root[31:1]);
         div0_in.rem[i]  = {1'b0, num[i][61:31]};
         div0_in.work[i] = num[i][30:0];
      end
   end

   assign dv_tag[0] = div0_tag_ff;
   assign dv_pl[0]  = div0_ff;

   // Divider chain.
   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      pfp_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (advance),
         .up_tag (dv_tag[k]),
         .up_div (dv_pl[k]),
         .dn_tag (dv_tag[k + 1]),
         .dn_div (dv_pl[k + 1])
      );
   end

   // Signed normal, then the products for the distance.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm_in[i] = dv_tag[DIV_N].neg[i] ? -$signed({1'b0, dv_pl[DIV_N].work[i]})
                                          : $signed({1'b0, dv_pl[DIV_N].work[i]});
         dprod_in[i] = nrm_ff[i] * $signed(f1_tag_ff.pt[i]);
      end
   end

   // Round half up, floor by 2^30, saturate, then pick by kind.
   always_comb begin
      acc  = dprod_ff[0] + dprod_ff[1] + dprod_ff[2] + pfp_pkg::ROUND_HALF;
      dsh  = acc >>> 30;
      dsat = dsh;
      if (dsh > pfp_pkg::DIST_MAX) begin
         dsat = pfp_pkg::DIST_MAX;
      end else if (dsh < pfp_pkg::DIST_MIN) begin
         dsat = pfp_pkg::DIST_MIN;
      end
      onx_in   = nrm2_ff[0];
      ony_in   = nrm2_ff[1];
      onz_in   = nrm2_ff[2];
      odist_in = dsat[34:0];
      odeg_in  = 1'b0;
      unique case (f2_tag_ff.kind)
         pfp_pkg::KIND_PLANE: begin
         end
         pfp_pkg::KIND_FLAT: begin
            onx_in   = '0;
            ony_in   = pfp_pkg::Q30_ONE;
            onz_in   = '0;
            odist_in = {{3{f2_tag_ff.pt[1][31]}}, f2_tag_ff.pt[1]};
         end
         default: begin
            onx_in   = '0;
            ony_in   = '0;
            onz_in   = '0;
            odist_in = '0;
            odeg_in  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div0_tag_ff.valid <= 1'b0;
         f1_tag_ff.valid   <= 1'b0;
         f2_tag_ff.valid   <= 1'b0;
         ovalid_ff         <= 1'b0;
      end else if (advance) begin
         div0_ff     <= div0_in;
         div0_tag_ff <= sq_tag[SQ_N];
         nrm_ff      <= nrm_in;
         f1_tag_ff   <= dv_tag[DIV_N];
         dprod_ff    <= dprod_in;
         nrm2_ff     <= nrm_ff;
         f2_tag_ff   <= f1_tag_ff;
         onx_ff      <= onx_in;
         ony_ff      <= ony_in;
         onz_ff      <= onz_in;
         odist_ff    <= odist_in;
         odeg_ff     <= odeg_in;
         ovalid_ff   <= f2_tag_ff.valid;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {5'b0, odist_ff, onz_ff, ony_ff, onx_ff};
   assign rsp_tuser  = odeg_ff;

   // A degenerate word carries a zero normal and distance.
   `PFP_CHECK(a_degen_zero, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[130:0] == 131'd0, "degenerate word not zero")
   // Nothing is offered right after reset.
   `PFP_CHECK_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_tvalid, "output valid after reset")
   // For a valid plane word, the scaled length lies in [2^30, 2^32).
   `PFP_CHECK(a_root_range, sq_tag[SQ_N].valid && sq_tag[SQ_N].kind == pfp_pkg::KIND_PLANE |-> sq_pl[SQ_N].root[63:32] == 32'd0 && sq_pl[SQ_N].root[31:30] != 2'd0, "length out of range")
   // No quotient of a valid plane word exceeds one in Q1.30.
   `PFP_CHECK(a_quot_bound, dv_tag[DIV_N].valid && dv_tag[DIV_N].kind == pfp_pkg::KIND_PLANE |-> dv_pl[DIV_N].work[0] <= 31'h4000_0000 && dv_pl[DIV_N].work[1] <= 31'h4000_0000 && dv_pl[DIV_N].work[2] <= 31'h4000_0000, "normal above one")

endmodule

>>> hw/rtl/pfp_front.sv
// ----------------------------------------------------------------------------
// Plane builder front end
// Point differences, cross product terms and the exact cross product.
// ----------------------------------------------------------------------------
module pfp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              up_valid,
   input  logic [1:0]        point_count,
   input  logic [2:0][31:0]  first_pt,
   input  logic [2:0][31:0]  second_pt,
   input  logic [2:0][31:0]  third_pt,
   output pfp_pkg::tag_type  dn_tag,
   output logic [2:0][66:0]  dn_cross
);

   localparam logic signed [32:0] ONE33 = 33'sd1;

   logic signed [32:0] diff_a [3];
   logic signed [32:0] diff_b [3];
   logic signed [32:0] lhs_in [6];
   logic signed [32:0] rhs_in [6];
   logic signed [32:0] lhs_ff [6];
   logic signed [32:0] rhs_ff [6];
   logic signed [65:0] prod_in [6];
   logic signed [65:0] prod_ff [6];
   logic [2:0][66:0]   cross_in;
   logic [2:0][66:0]   cross_ff;
   pfp_pkg::tag_type   tag_in;
   pfp_pkg::tag_type   tag1_ff;
   pfp_pkg::tag_type   tag2_ff;
   pfp_pkg::tag_type   tag3_ff;

   // Differences and selection of the multiplier operands.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_a[i] = $signed({first_pt[i][31], first_pt[i]}) -
                     $signed({second_pt[i][31], second_pt[i]});
         diff_b[i] = $signed({second_pt[i][31], second_pt[i]}) -
                     $signed({third_pt[i][31], third_pt[i]});
      end
      for (int k = 0; k < 6; k++) begin
         lhs_in[k] = '0;
         rhs_in[k] = '0;
      end
      tag_in.valid = up_valid;
      tag_in.neg   = '0;
      tag_in.pt    = (point_count == pfp_pkg::COUNT_THREE) ? third_pt : first_pt;
      unique case (point_count) inside
         pfp_pkg::COUNT_ONE: begin
            tag_in.kind = pfp_pkg::KIND_FLAT;
         end
         pfp_pkg::COUNT_TWO: begin
            // Cross with the up axis: (-dz, 0, dx).
            tag_in.kind = pfp_pkg::KIND_PLANE;
            lhs_in[1]   = diff_a[2];
            rhs_in[1]   = ONE33;
            lhs_in[4]   = diff_a[0];
            rhs_in[4]   = ONE33;
         end
         pfp_pkg::COUNT_THREE: begin
            tag_in.kind = pfp_pkg::KIND_PLANE;
            lhs_in[0] = diff_a[1]; rhs_in[0] = diff_b[2];
            lhs_in[1] = diff_a[2]; rhs_in[1] = diff_b[1];
            lhs_in[2] = diff_a[2]; rhs_in[2] = diff_b[0];
            lhs_in[3] = diff_a[0]; rhs_in[3] = diff_b[2];
            lhs_in[4] = diff_a[0]; rhs_in[4] = diff_b[1];
            lhs_in[5] = diff_a[1]; rhs_in[5] = diff_b[0];
         end
         default: begin
            tag_in.kind = pfp_pkg::KIND_DEGEN;
         end
      endcase
   end

   // Six products and the three cross product differences.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         prod_in[k] = lhs_ff[k] * rhs_ff[k];
      end
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = $signed({prod_ff[2 * i][65], prod_ff[2 * i]}) -
                       $signed({prod_ff[2 * i + 1][65], prod_ff[2 * i + 1]});
      end
   end

   // Three pipeline stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else if (en) begin
         lhs_ff   <= lhs_in;
         rhs_ff   <= rhs_in;
         prod_ff  <= prod_in;
         cross_ff <= cross_in;
         tag1_ff  <= tag_in;
         tag2_ff  <= tag1_ff;
         tag3_ff  <= tag2_ff;
      end
   end

   assign dn_tag   = tag3_ff;
   assign dn_cross = cross_ff;

endmodule

>>> hw/rtl/pfp_norm.sv
// ----------------------------------------------------------------------------
// Plane builder scaling
// Magnitudes, common scaling to 31 bits, squares and their sum.
// ----------------------------------------------------------------------------
module pfp_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pfp_pkg::tag_type  up_tag,
   input  logic [2:0][66:0]  up_cross,
   output pfp_pkg::tag_type  dn_tag,
   output pfp_pkg::sqrt_type dn_sq
);

   logic [2:0][66:0]  mag_in;
   logic [2:0][66:0]  mag1_ff;
   logic [2:0][66:0]  mag2_ff;
   logic [6:0]        blen_in;
   logic [6:0]        blen_ff;
   logic [97:0]       wide [3];
   logic [2:0][30:0]  scl_in;
   logic [2:0][30:0]  scl3_ff;
   logic [2:0][30:0]  scl4_ff;
   logic [2:0][30:0]  scl5_ff;
   logic [61:0]       sqr_in [3];
   logic [61:0]       sqr_ff [3];
   logic [63:0]       sum_in;
   logic [63:0]       sum_ff;
   pfp_pkg::tag_type  tag_a_in;
   pfp_pkg::tag_type  tag_s_in;
   pfp_pkg::tag_type  tag1_ff;
   pfp_pkg::tag_type  tag2_ff;
   pfp_pkg::tag_type  tag3_ff;
   pfp_pkg::tag_type  tag4_ff;
   pfp_pkg::tag_type  tag5_ff;

   // Sign and magnitude of each component.
   always_comb begin
      tag_a_in = up_tag;
      for (int i = 0; i < 3; i++) begin
         tag_a_in.neg[i] = up_cross[i][66];
         mag_in[i] = up_cross[i][66] ? 67'(-$signed(up_cross[i])) : up_cross[i];
      end
   end

   // Length of the largest magnitude.
   assign blen_in = pfp_pkg::bit_length(mag1_ff[0] | mag1_ff[1] | mag1_ff[2]);

   // One common shift puts the largest magnitude in [2^30, 2^31).
   always_comb begin
      tag_s_in = tag2_ff;
      for (int i = 0; i < 3; i++) begin
         wide[i]   = {mag2_ff[i], 31'b0} >> blen_ff;
         scl_in[i] = wide[i][30:0];
      end
      if (tag2_ff.kind == pfp_pkg::KIND_PLANE && blen_ff == 7'd0) begin
         tag_s_in.kind = pfp_pkg::KIND_DEGEN;
      end
   end

   // Squares and their sum.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sqr_in[i] = scl3_ff[i] * scl3_ff[i];
      end
      sum_in = 64'(sqr_ff[0]) + 64'(sqr_ff[1]) + 64'(sqr_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
         tag5_ff.valid <= 1'b0;
      end else if (en) begin
         mag1_ff <= mag_in;
         mag2_ff <= mag1_ff;
         blen_ff <= blen_in;
         scl3_ff <= scl_in;
         scl4_ff <= scl3_ff;
         scl5_ff <= scl4_ff;
         sqr_ff  <= sqr_in;
         sum_ff  <= sum_in;
         tag1_ff <= tag_a_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag_s_in;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
      end
   end

   assign dn_tag     = tag5_ff;
   assign dn_sq.rem  = sum_ff;
   assign dn_sq.root = '0;
   assign dn_sq.bitv = pfp_pkg::SQRT_FIRST_BIT;
   assign dn_sq.mag  = scl5_ff;

endmodule

>>> hw/rtl/pfp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One digit-by-digit square root step, registered toward the next cell.
// ----------------------------------------------------------------------------
module pfp_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pfp_pkg::tag_type  up_tag,
   input  pfp_pkg::sqrt_type up_sq,
   output pfp_pkg::tag_type  dn_tag,
   output pfp_pkg::sqrt_type dn_sq
);

   logic [63:0]       trial;
   pfp_pkg::sqrt_type sq_in;
   pfp_pkg::sqrt_type sq_ff;
   pfp_pkg::tag_type  tag_ff;

   // Try the current bit; keep it when the remainder allows.
   always_comb begin
      trial      = up_sq.root + up_sq.bitv;
      sq_in      = up_sq;
      sq_in.bitv = up_sq.bitv >> 2;
      if (up_sq.rem >= trial) begin
         sq_in.rem  = up_sq.rem - trial;
         sq_in.root = (up_sq.root >> 1) + up_sq.bitv;
      end else begin
         sq_in.root = up_sq.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (en) begin
         sq_ff  <= sq_in;
         tag_ff <= up_tag;
      end
   end

   assign dn_tag = tag_ff;
   assign dn_sq  = sq_ff;

endmodule

>>> hw/rtl/pfp_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step on three lanes that share the divisor.
// ----------------------------------------------------------------------------
module pfp_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  pfp_pkg::tag_type up_tag,
   input  pfp_pkg::div_type up_div,
   output pfp_pkg::tag_type dn_tag,
   output pfp_pkg::div_type dn_div
);

   logic [32:0]      trial [3];
   logic             qbit  [3];
   pfp_pkg::div_type div_in;
   pfp_pkg::div_type div_ff;
   pfp_pkg::tag_type tag_ff;

   // Shift in the next dividend bit, subtract when it fits.
   always_comb begin
      div_in = up_div;
      for (int i = 0; i < 3; i++) begin
         trial[i] = {up_div.rem[i], up_div.work[i][30]};
         qbit[i]  = trial[i] >= {1'b0, up_div.len};
         if (qbit[i]) begin
            div_in.rem[i] = 32'(trial[i] - {1'b0, up_div.len});
         end else begin
            div_in.rem[i] = trial[i][31:0];
         end
         div_in.work[i] = {up_div.work[i][29:0], qbit[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (en) begin
         div_ff <= div_in;
         tag_ff <= up_tag;
      end
   end

   assign dn_tag = tag_ff;
   assign dn_div = div_ff;

endmodule
